FILE: design/mqrb_pkg.sv
package mqrb_pkg;

    // field widths fixed by the item format
    localparam int OP_W   = 2;
    localparam int QID_W  = 4;
    localparam int RS_W   = 5;
    localparam int DATA_W = 32;
    localparam int ST_W   = 3;
    localparam int OCC_W  = 4;

    // ring lengths never exceed what the size field can carry
    localparam int RS_MAX = (1 << RS_W) - 1;
    // pointer and length arithmetic width, one bit over the size field
    localparam int ARITH_W = RS_W + 1;

    localparam int NUM_QUEUES_DEF = 16;
    localparam int MAX_RING_DEF   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_ID   = 3'd3,
        ST_BAD_SIZE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_LOAD
    } ctrl_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } ctrl_cmd_t;

endpackage

FILE: design/mqrb_req_if.sv
interface mqrb_req_if;
    import mqrb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [QID_W-1:0]         queue_id;
    logic [RS_W-1:0]          ring_size;
    logic signed [DATA_W-1:0] frame_value;
    logic signed [DATA_W-1:0] frame_tag;

    modport source (
        output valid, operation, queue_id, ring_size, frame_value, frame_tag,
        input  ready
    );

    modport sink (
        input  valid, operation, queue_id, ring_size, frame_value, frame_tag,
        output ready
    );
endinterface

FILE: design/mqrb_rsp_if.sv
interface mqrb_rsp_if;
    import mqrb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [QID_W-1:0]         result_queue;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_tag;
    logic [OCC_W-1:0]         occupancy;

    modport source (
        output valid, status, result_queue, out_value, out_tag, occupancy,
        input  ready
    );

    modport sink (
        input  valid, status, result_queue, out_value, out_tag, occupancy,
        output ready
    );
endinterface

FILE: design/multi_queue_ring_buffer_bank.sv
// channel  dir  payload                                                  accepted when
// req      in   operation, queue_id, ring_size, frame_value, frame_tag   valid && ready
// rsp      out  status, result_queue, out_value, out_tag, occupancy      valid && ready
//
// each item goes through capture, execute (pointer table update and
// frame memory access), then load of the output register with the registered
// memory read data; no new item is accepted until the load step is done
// a new item is accepted while the previous result still waits in the output
// register; a stalled rsp holds the load step until the register frees up
// asynchronous reset clears the pointer table and the id counter; the frame
// memory is not cleared and needs no clearing pass
module multi_queue_ring_buffer_bank #(
    parameter int NUM_QUEUES = mqrb_pkg::NUM_QUEUES_DEF,
    parameter int MAX_RING   = mqrb_pkg::MAX_RING_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mqrb_req_if.sink          req,
    mqrb_rsp_if.source        rsp
);
    import mqrb_pkg::*;

    ctrl_cmd_t cmd;

    // sequencing
    mqrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // pointer table, frame memory and result registers
    mqrb_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .MAX_RING   (MAX_RING)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (req.operation),
        .queue_id     (req.queue_id),
        .ring_size    (req.ring_size),
        .frame_value  (req.frame_value),
        .frame_tag    (req.frame_tag),
        .status       (rsp.status),
        .result_queue (rsp.result_queue),
        .out_value    (rsp.out_value),
        .out_tag      (rsp.out_tag),
        .occupancy    (rsp.occupancy)
    );

endmodule

FILE: design/mqrb_ctrl.sv
module mqrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mqrb_pkg::ctrl_cmd_t  cmd
);
    import mqrb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // state and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing: capture, execute, load into output register
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = CS_LOAD;
            end
            CS_LOAD:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/mqrb_dp.sv
module mqrb_dp #(
    parameter int NUM_QUEUES = mqrb_pkg::NUM_QUEUES_DEF,
    parameter int MAX_RING   = mqrb_pkg::MAX_RING_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mqrb_pkg::ctrl_cmd_t               cmd,
    input  logic [mqrb_pkg::OP_W-1:0]         operation,
    input  logic [mqrb_pkg::QID_W-1:0]        queue_id,
    input  logic [mqrb_pkg::RS_W-1:0]         ring_size,
    input  logic signed [mqrb_pkg::DATA_W-1:0] frame_value,
    input  logic signed [mqrb_pkg::DATA_W-1:0] frame_tag,
    output logic [mqrb_pkg::ST_W-1:0]         status,
    output logic [mqrb_pkg::QID_W-1:0]        result_queue,
    output logic signed [mqrb_pkg::DATA_W-1:0] out_value,
    output logic signed [mqrb_pkg::DATA_W-1:0] out_tag,
    output logic [mqrb_pkg::OCC_W-1:0]        occupancy
);
    import mqrb_pkg::*;

    // only ids that the queue_id field can name get pointer storage
    localparam int NQ_EFF  = (NUM_QUEUES < (1 << QID_W)) ? NUM_QUEUES : (1 << QID_W);
    localparam int QW      = (NQ_EFF > 1) ? $clog2(NQ_EFF) : 1;
    localparam int QM_W    = $clog2(NUM_QUEUES + 1);
    localparam int CMP_W   = (QM_W > QID_W) ? QM_W : QID_W;
    localparam int LEN_MAX = (MAX_RING < RS_MAX) ? MAX_RING : RS_MAX;
    localparam int PTR_W   = $clog2(LEN_MAX);
    localparam int DEPTH   = NQ_EFF * MAX_RING;
    localparam int ADDR_W  = $clog2(DEPTH);

    // captured item
    op_t                op_reg;
    logic [QID_W-1:0]   qid_reg;
    logic [RS_W-1:0]    size_reg;
    logic [DATA_W-1:0]  fval_reg;
    logic [DATA_W-1:0]  ftag_reg;

    // per-queue pointer table
    logic [PTR_W-1:0]   head_reg [NQ_EFF];
    logic [PTR_W-1:0]   tail_reg [NQ_EFF];
    logic [RS_W-1:0]    len_reg  [NQ_EFF];
    logic [QM_W-1:0]    qmade_reg;

    // shared frame memory, tag in the upper half
    logic [2*DATA_W-1:0] mem [DEPTH];
    logic [2*DATA_W-1:0] rd_data_reg;

    // result waiting for the memory read
    status_t            pend_status_reg;
    logic [QID_W-1:0]   pend_rq_reg;
    logic [OCC_W-1:0]   pend_occ_reg;
    logic               pend_data_reg;

    // output register
    status_t            status_reg;
    logic [QID_W-1:0]   rq_reg;
    logic [DATA_W-1:0]  value_reg;
    logic [DATA_W-1:0]  tag_reg;
    logic [OCC_W-1:0]   occ_reg;

    // execute-cycle decode
    logic [QW-1:0]      qidx;
    logic [QW-1:0]      new_idx;
    logic               id_ok;
    logic               ids_used;
    logic               size_bad;
    logic               slot_free;
    logic [PTR_W-1:0]   head_cur;
    logic [PTR_W-1:0]   tail_cur;
    logic [RS_W-1:0]    len_cur;
    logic [ARITH_W-1:0] head_inc;
    logic [ARITH_W-1:0] tail_inc;
    logic [PTR_W-1:0]   head_nxt;
    logic [PTR_W-1:0]   tail_nxt;
    logic [PTR_W-1:0]   head_new;
    logic [PTR_W-1:0]   tail_new;
    logic [ARITH_W-1:0] occ_wide;
    logic               create_ok;
    logic               write_ok;
    logic               pop_ok;
    logic               data_ok;
    status_t            exec_status;
    logic [QID_W-1:0]   exec_rq;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(operation);
            qid_reg  <= queue_id;
            size_reg <= ring_size;
            fval_reg <= frame_value;
            ftag_reg <= frame_tag;
        end
    end

    // decode and pointer arithmetic for the captured item
    always_comb
    begin
        qidx      = qid_reg[QW-1:0];
        new_idx   = qmade_reg[QW-1:0];
        id_ok     = CMP_W'(qid_reg) < CMP_W'(qmade_reg);
        ids_used  = qmade_reg >= QM_W'(NUM_QUEUES);
        size_bad  = (size_reg < RS_W'(2)) || (32'(size_reg) > 32'(MAX_RING));
        slot_free = qmade_reg < QM_W'(NQ_EFF);
        head_cur  = head_reg[qidx];
        tail_cur  = tail_reg[qidx];
        len_cur   = len_reg[qidx];

        // ring advance wraps at the queue's own length
        head_inc = ARITH_W'(head_cur) + ARITH_W'(1);
        tail_inc = ARITH_W'(tail_cur) + ARITH_W'(1);
        head_nxt = (head_inc >= ARITH_W'(len_cur)) ? '0 : head_inc[PTR_W-1:0];
        tail_nxt = (tail_inc >= ARITH_W'(len_cur)) ? '0 : tail_inc[PTR_W-1:0];

        create_ok   = 1'b0;
        write_ok    = 1'b0;
        pop_ok      = 1'b0;
        data_ok     = 1'b0;
        exec_status = ST_OK;
        exec_rq     = qid_reg;
        head_new    = head_cur;
        tail_new    = tail_cur;

        if (op_reg == OP_CREATE)
        begin
            exec_rq = '0;
            if (ids_used)
            begin
                exec_status = ST_BAD_ID;
            end
            else if (size_bad)
            begin
                exec_status = ST_BAD_SIZE;
            end
            else
            begin
                create_ok = 1'b1;
                exec_rq   = QID_W'(qmade_reg);
            end
        end
        else if (!id_ok)
        begin
            exec_status = ST_BAD_ID;
        end
        else if (op_reg == OP_WRITE)
        begin
            if (head_nxt == tail_cur)
            begin
                exec_status = ST_FULL;
            end
            else
            begin
                write_ok = 1'b1;
                head_new = head_nxt;
            end
        end
        else if (head_cur == tail_cur)
        begin
            exec_status = ST_EMPTY;
        end
        else
        begin
            data_ok = 1'b1;
            if (op_reg == OP_READ)
            begin
                pop_ok   = 1'b1;
                tail_new = tail_nxt;
            end
        end

        // occupancy after the operation, zero for create and bad ids
        if (head_new >= tail_new)
        begin
            occ_wide = ARITH_W'(head_new) - ARITH_W'(tail_new);
        end
        else
        begin
            occ_wide = ARITH_W'(head_new) + ARITH_W'(len_cur) - ARITH_W'(tail_new);
        end
        if (op_reg == OP_CREATE || !id_ok)
        begin
            occ_wide = '0;
        end

        // slot addresses inside the queue's region
        base_addr = ADDR_W'(qidx) * ADDR_W'(MAX_RING);
        wr_addr   = base_addr + ADDR_W'(head_cur);
        rd_addr   = base_addr + ADDR_W'(tail_cur);
    end

    // pointer table and id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmade_reg <= '0;
            for (int i = 0; i < NQ_EFF; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
        end
        else if (cmd.execute)
        begin
            if (create_ok)
            begin
                qmade_reg <= qmade_reg + QM_W'(1);
                if (slot_free)
                begin
                    head_reg[new_idx] <= '0;
                    tail_reg[new_idx] <= '0;
                    len_reg[new_idx]  <= size_reg;
                end
            end
            if (write_ok)
            begin
                head_reg[qidx] <= head_new;
            end
            if (pop_ok)
            begin
                tail_reg[qidx] <= tail_new;
            end
        end
    end

    // frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.execute && write_ok)
        begin
            mem[wr_addr] <= {ftag_reg, fval_reg};
        end
        if (cmd.execute)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // hold the result while the memory read completes
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            pend_status_reg <= exec_status;
            pend_rq_reg     <= exec_rq;
            pend_occ_reg    <= OCC_W'(occ_wide);
            pend_data_reg   <= data_ok;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= pend_status_reg;
            rq_reg     <= pend_rq_reg;
            occ_reg    <= pend_occ_reg;
            value_reg  <= pend_data_reg ? rd_data_reg[DATA_W-1:0] : '0;
            tag_reg    <= pend_data_reg ? rd_data_reg[2*DATA_W-1:DATA_W] : '0;
        end
    end

    assign status       = status_reg;
    assign result_queue = rq_reg;
    assign out_value    = value_reg;
    assign out_tag      = tag_reg;
    assign occupancy    = occ_reg;

endmodule

FILE: design/mqrb_checker.sv
module mqrb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [mqrb_pkg::ST_W-1:0]         status,
    input  logic signed [mqrb_pkg::DATA_W-1:0] out_value,
    input  logic signed [mqrb_pkg::DATA_W-1:0] out_tag,
    input  logic [mqrb_pkg::OCC_W-1:0]        occupancy
);
    import mqrb_pkg::*;

    // a stalled result keeps its valid
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(out_value)
            && $stable(out_tag) && $stable(occupancy))
        else $error("result payload changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while previous one in work");

    // frame fields carry data only on a successful read or peek
    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> out_value == 0 && out_tag == 0)
        else $error("frame data on a failed operation");

    // bad id or size reports zero occupancy
    a_bad_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_BAD_ID || status == ST_BAD_SIZE)
            |-> occupancy == 0)
        else $error("occupancy nonzero on a rejected operation");

endmodule

bind multi_queue_ring_buffer_bank mqrb_checker u_mqrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_value (rsp.out_value),
    .out_tag   (rsp.out_tag),
    .occupancy (rsp.occupancy)
);
